// ===== hw/rtl/march_c_minus_ram_bist_unit_macros.svh =====
// assertion helpers for the march c- bist unit
`ifndef MARCH_C_MINUS_RAM_BIST_UNIT_MACROS_SVH
`define MARCH_C_MINUS_RAM_BIST_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MCMB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCMB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mcmb_pkg.sv =====
`default_nettype none
package mcmb_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned CNT_W  = 17;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_RUN     = 2'd0,
		ST_PASS    = 2'd1,
		ST_FAIL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// action codes of an input word
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// register indexes (byte address bit 2)
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// march elements
	localparam logic [2:0] ELEM_UP_W0     = 3'd0;
	localparam logic [2:0] ELEM_UP_R0W1   = 3'd1;
	localparam logic [2:0] ELEM_UP_R1W0   = 3'd2;
	localparam logic [2:0] ELEM_DN_R0W1   = 3'd3;
	localparam logic [2:0] ELEM_DN_R1W0   = 3'd4;
	localparam logic [2:0] ELEM_DN_R0     = 3'd5;
	localparam logic [2:0] ELEM_DONE      = 3'd6;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [CNT_W-1:0]  count;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mcmb_regs.sv =====
`default_nettype none
module mcmb_regs
	import mcmb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_BASE:  cfg_q.base  <= pwdata[ADDR_W-1:0];
				REG_COUNT: cfg_q.count <= pwdata[CNT_W-1:0];
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BASE:  prdata = cfg_q.base;
			REG_COUNT: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_q.count};
			default:   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/march_c_minus_ram_bist_unit.sv =====
// March C- memory test sequencer. After the base and count registers are set over the
// register port, a start word (action 0) checks the set-up and arms the test; each step
// word (action 1) carries the data returned for the previous read and yields the next
// memory command (none, read or write) with its byte address and write pattern, running
// up w0; up r0,w1; up r1,w0; down r0,w1; down r1,w0; down r0. A zero base, a zero count
// or a count above MAX_WORDS finishes at once with invalid status; the first read
// mismatch finishes with fail; a step after the last read check finishes with pass.
// Every input word yields exactly one result word. The unit takes one word per clock
// cycle: a word sits in the input register while the sequencer logic works out the
// command and the next state, and then lands in the result register; input is held
// off only while a result waits on out_stall.
// Registers are sampled at start; writes during a test take effect at the next start.
`default_nettype none
`include "march_c_minus_ram_bist_unit_macros.svh"
module march_c_minus_ram_bist_unit
	import mcmb_pkg::*;
#(
	parameter int unsigned MAX_WORDS = 65536,
	parameter int unsigned DATA_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// apb register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// input word channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               action,
	input  wire logic [31:0]        read_data,
	// result word channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [1:0]         command,
	output logic      [ADDR_W-1:0]  mem_address,
	output logic      [31:0]        write_data,
	output logic      [1:0]         status,
	output logic                    finished
);

	// word index wide enough for MAX_WORDS - 1
	localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	// all-ones pattern over DATA_BITS, kept 64 wide
	localparam logic [63:0] ONES64 = {64{1'b1}} >> (64 - DATA_BITS);

	cfg_t cfg;

	mcmb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic        valid_s1;
	logic        action_s1;
	logic [31:0] read_data_s1;

	// sequencer state
	logic [2:0]        elem_q;
	logic [IDX_W-1:0]  idx_q;
	logic              read_pending_q;
	logic              write_next_q;
	logic              running_q;
	status_t           test_status_q;
	logic [ADDR_W-1:0] act_base_q;
	logic [CNT_W-1:0]  act_count_q;

	// result register
	logic              out_valid_q;
	cmd_t              command_q;
	logic [ADDR_W-1:0] mem_address_q;
	logic [31:0]       write_data_q;
	status_t           status_q;
	logic              finished_q;

	logic adv;
	logic fire;
	logic in_take;

	// result register free, or emptied this cycle
	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// input register loads whenever it is not holding a stalled word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1    <= action;
			read_data_s1 <= read_data;
		end
	end

	// ---------------------------------------------------------------------
	// sequencer step logic
	// ---------------------------------------------------------------------
	logic [63:0]          rd64;
	logic [DATA_BITS-1:0] rd_cmp;
	logic [DATA_BITS-1:0] rd_expect;
	logic [63:0]          wr_pat64;
	logic                 mismatch;
	logic                 setup_bad;
	logic [IDX_W-1:0]     last_idx;
	logic [2:0]           elem_inc;
	logic [2:0]           adv_elem;
	logic [IDX_W-1:0]     adv_idx;
	logic [ADDR_W-1:0]    cur_addr;

	logic [2:0]        n_elem;
	logic [IDX_W-1:0]  n_idx;
	logic              n_read_pending;
	logic              n_write_next;
	logic              n_running;
	status_t           n_test_status;
	logic [ADDR_W-1:0] n_act_base;
	logic [CNT_W-1:0]  n_act_count;

	cmd_t              r_command;
	logic [ADDR_W-1:0] r_address;
	logic [31:0]       r_wdata;
	status_t           r_status;
	logic              r_finished;

	assign rd64   = {32'd0, read_data_s1};
	assign rd_cmp = rd64[DATA_BITS-1:0];

	// ones expected in the r1 elements, ones written in the w1 elements
	assign rd_expect = (elem_q == ELEM_UP_R1W0 || elem_q == ELEM_DN_R1W0) ?
		ONES64[DATA_BITS-1:0] : '0;
	assign wr_pat64 = (elem_q == ELEM_UP_R0W1 || elem_q == ELEM_DN_R0W1) ? ONES64 : 64'd0;
	assign mismatch = read_pending_q && (rd_cmp != rd_expect);

	assign setup_bad = (cfg.base == '0) || (cfg.count == '0) ||
		({15'd0, cfg.count} > 32'(MAX_WORDS));

	assign last_idx = IDX_W'(act_count_q - CNT_W'(1));
	assign elem_inc = elem_q + 3'd1;
	assign cur_addr = act_base_q + (ADDR_W'(idx_q) << 2);

	// next position along the march
	always_comb begin
		adv_elem = elem_q;
		adv_idx  = idx_q;
		if (elem_q <= ELEM_UP_R1W0) begin
			// ascending elements
			if (32'(idx_q) + 32'd1 >= 32'(act_count_q)) begin
				adv_elem = elem_inc;
				adv_idx  = (elem_inc == ELEM_DN_R0W1) ? last_idx : '0;
			end else begin
				adv_idx = idx_q + IDX_W'(1);
			end
		end else begin
			// descending elements
			if (idx_q == '0) begin
				adv_elem = elem_inc;
				adv_idx  = (elem_inc < ELEM_DONE) ? last_idx : '0;
			end else begin
				adv_idx = idx_q - IDX_W'(1);
			end
		end
	end

	always_comb begin
		n_elem         = elem_q;
		n_idx          = idx_q;
		n_read_pending = read_pending_q;
		n_write_next   = write_next_q;
		n_running      = running_q;
		n_test_status  = test_status_q;
		n_act_base     = act_base_q;
		n_act_count    = act_count_q;
		r_command      = CMD_NONE;
		r_address      = '0;
		r_wdata        = '0;
		r_status       = test_status_q;
		r_finished     = 1'b0;

		if (action_s1 == ACT_START) begin
			n_read_pending = 1'b0;
			n_write_next   = 1'b0;
			n_elem         = ELEM_UP_W0;
			n_idx          = '0;
			if (setup_bad) begin
				n_running     = 1'b0;
				n_test_status = ST_INVALID;
				r_status      = ST_INVALID;
				r_finished    = 1'b1;
			end else begin
				n_act_base    = cfg.base;
				n_act_count   = cfg.count;
				n_running     = 1'b1;
				n_test_status = ST_RUN;
				r_status      = ST_RUN;
			end
		end else if (running_q) begin
			n_read_pending = 1'b0;
			if (mismatch) begin
				n_running     = 1'b0;
				n_test_status = ST_FAIL;
				r_status      = ST_FAIL;
				r_finished    = 1'b1;
			end else if (elem_q >= ELEM_DONE) begin
				n_running     = 1'b0;
				n_test_status = ST_PASS;
				r_status      = ST_PASS;
				r_finished    = 1'b1;
			end else begin
				r_address = cur_addr;
				r_status  = ST_RUN;
				if (elem_q == ELEM_UP_W0) begin
					r_command = CMD_WRITE;
					r_wdata   = wr_pat64[31:0];
					n_elem    = adv_elem;
					n_idx     = adv_idx;
				end else if (elem_q == ELEM_DN_R0) begin
					r_command      = CMD_READ;
					n_read_pending = 1'b1;
					n_elem         = adv_elem;
					n_idx          = adv_idx;
				end else if (!write_next_q) begin
					r_command      = CMD_READ;
					n_read_pending = 1'b1;
					n_write_next   = 1'b1;
				end else begin
					r_command    = CMD_WRITE;
					r_wdata      = wr_pat64[31:0];
					n_write_next = 1'b0;
					n_elem       = adv_elem;
					n_idx        = adv_idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q         <= ELEM_UP_W0;
			idx_q          <= '0;
			read_pending_q <= 1'b0;
			write_next_q   <= 1'b0;
			running_q      <= 1'b0;
			test_status_q  <= ST_RUN;
			act_base_q     <= '0;
			act_count_q    <= '0;
		end else if (fire) begin
			elem_q         <= n_elem;
			idx_q          <= n_idx;
			read_pending_q <= n_read_pending;
			write_next_q   <= n_write_next;
			running_q      <= n_running;
			test_status_q  <= n_test_status;
			act_base_q     <= n_act_base;
			act_count_q    <= n_act_count;
		end
	end

	// result register, refilled whenever it empties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			command_q     <= r_command;
			mem_address_q <= r_address;
			write_data_q  <= r_wdata;
			status_q      <= r_status;
			finished_q    <= r_finished;
		end
	end

	assign out_valid   = out_valid_q;
	assign command     = command_q;
	assign mem_address = mem_address_q;
	assign write_data  = write_data_q;
	assign status      = status_q;
	assign finished    = finished_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	`MCMB_ASSERT_NOW(a_fin_no_access, out_valid_q && finished_q, command_q == CMD_NONE,
		"finishing word carries a memory access")
	`MCMB_ASSERT_NOW(a_pending_needs_run, read_pending_q, running_q,
		"read check pending while idle")
	`MCMB_ASSERT_NOW(a_elem_range, 1'b1, elem_q <= ELEM_DONE,
		"march element past the end")
	`MCMB_ASSERT_NEXT(a_stall_holds_s1, in_stall, valid_s1,
		"input register dropped a word while held off")

endmodule
`default_nettype wire

// ===== tb/sv/march_c_minus_ram_bist_unit_tb.sv =====
`timescale 1ns / 100ps
module march_c_minus_ram_bist_unit_tb;
	import mcmb_pkg::*;

	localparam int unsigned MAX_WORDS = 65536;
	localparam logic [31:0] ZEROS = 32'h0000_0000;
	localparam logic [31:0] ONES = 32'hFFFF_FFFF;
	localparam int unsigned CYCLE_LIMIT = 500000;
	// two-stage pipeline, a few spare cycles are plenty
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_WORDS = 700;

	// one input word as queued by the stimulus: read data is settled when it is driven
	typedef struct {
		logic        act;
		logic        corrupt; // spoil the data of a pending read
		logic        drain;   // hold back until every result is in
		logic [31:0] noise;
	} bist_word_t;

	// one result word of the sequencer
	typedef struct {
		cmd_t        cmd;
		logic [31:0] addr;
		logic [31:0] wdata;
		status_t     st;
		logic        fin;
	} cmd_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_STEP;
	logic [31:0] read_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] command;
	logic [ADDR_W-1:0] mem_address;
	logic [31:0] write_data;
	logic [1:0] status;
	logic finished;

	march_c_minus_ram_bist_unit #(
		.MAX_WORDS(MAX_WORDS),
		.DATA_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.read_data(read_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.command(command),
		.mem_address(mem_address),
		.write_data(write_data),
		.status(status),
		.finished(finished)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	bist_word_t queued_words[$];
	cmd_word_t due_commands[$];
	int fail_count = 0;
	int words_made = 0;
	int words_taken = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	logic took_word = 1'b0;
	bit no_idle = 1'b0;

	// sequencer shadow: register copies, then the state of the test in progress
	logic [31:0] cfg_base_q = '0;
	logic [16:0] cfg_count_q = '0;
	logic [2:0] elem = ELEM_UP_W0;
	logic [15:0] widx = '0;
	logic read_outstanding = 1'b0;
	logic write_due = 1'b0;
	logic test_active = 1'b0;
	status_t last_status = ST_RUN;
	logic [31:0] run_base = '0;
	logic [16:0] run_count = '0;

	// the r1 elements expect ones back, every other read expects zeros
	function automatic logic [31:0] read_pattern(logic [2:0] e);
		return (e == ELEM_UP_R1W0 || e == ELEM_DN_R1W0) ? ONES : ZEROS;
	endfunction

	// w1 belongs to the r0,w1 elements
	function automatic logic [31:0] write_pattern(logic [2:0] e);
		return (e == ELEM_UP_R0W1 || e == ELEM_DN_R0W1) ? ONES : ZEROS;
	endfunction

	// move to the next word; up elements count up, down elements count down
	function automatic void next_word();
		if (elem <= ELEM_UP_R1W0) begin
			if ({1'b0, widx} + 17'd1 >= run_count) begin
				elem = elem + 3'd1;
				widx = (elem == ELEM_DN_R0W1) ? 16'(run_count - 17'd1) : 16'd0;
			end else begin
				widx = widx + 16'd1;
			end
		end else begin
			if (widx == 16'd0) begin
				elem = elem + 3'd1;
				widx = (elem < ELEM_DONE) ? 16'(run_count - 17'd1) : 16'd0;
			end else begin
				widx = widx - 16'd1;
			end
		end
	endfunction

	// result of one input word, updating the shadow state
	function automatic cmd_word_t march_step(logic act, logic [31:0] rdata);
		cmd_word_t r;
		r.cmd = CMD_NONE;
		r.addr = '0;
		r.wdata = '0;
		r.st = ST_RUN;
		r.fin = 1'b0;
		if (act == ACT_START) begin
			read_outstanding = 1'b0;
			write_due = 1'b0;
			elem = ELEM_UP_W0;
			widx = '0;
			if (cfg_base_q == '0 || cfg_count_q == '0 || cfg_count_q > MAX_WORDS) begin
				test_active = 1'b0;
				last_status = ST_INVALID;
				r.st = ST_INVALID;
				r.fin = 1'b1;
			end else begin
				run_base = cfg_base_q;
				run_count = cfg_count_q;
				test_active = 1'b1;
				last_status = ST_RUN;
			end
			return r;
		end
		// step while idle just reports the last status
		if (!test_active) begin
			r.st = last_status;
			return r;
		end
		// data of the previous read is checked first
		if (read_outstanding) begin
			read_outstanding = 1'b0;
			if (rdata != read_pattern(elem)) begin
				test_active = 1'b0;
				last_status = ST_FAIL;
				r.st = ST_FAIL;
				r.fin = 1'b1;
				return r;
			end
		end
		if (elem >= ELEM_DONE) begin
			test_active = 1'b0;
			last_status = ST_PASS;
			r.st = ST_PASS;
			r.fin = 1'b1;
			return r;
		end
		// byte address wraps at 32 bits, misaligned bases are kept as they are
		r.addr = run_base + {14'd0, widx, 2'b00};
		if (elem == ELEM_UP_W0 || write_due) begin
			r.cmd = CMD_WRITE;
			r.wdata = write_pattern(elem);
			write_due = 1'b0;
			next_word();
		end else begin
			r.cmd = CMD_READ;
			read_outstanding = 1'b1;
			if (elem == ELEM_DN_R0)
				next_word();
			else
				write_due = 1'b1;
		end
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// reset, held low from the start and released at a falling edge
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// input side: each accepted word is run through the shadow sequencer
	always @(posedge clk) begin
		took_word <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			due_commands.push_back(march_step(action, read_data));
			words_taken++;
		end
	end

	// word driver: holds a stalled word, otherwise idles or loads the next word
	always @(negedge clk) begin
		bist_word_t w;
		logic [31:0] good;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !took_word) begin
			// stalled, payload stays put
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (queued_words.size() != 0 &&
				!(queued_words[0].drain && due_commands.size() != 0)) begin
			w = queued_words.pop_front();
			// a pending read gets the right pattern unless the word is meant to spoil it;
			// the shadow state is already past every earlier word here
			good = read_pattern(elem);
			action <= w.act;
			if (w.act == ACT_STEP && test_active && read_outstanding)
				read_data <= w.corrupt ? (good ^ w.noise) : good;
			else
				read_data <= w.noise;
			in_valid <= 1'b1;
			gap_left <= pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		cmd_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (due_commands.size() == 0) begin
				$error("result word with nothing expected: command %0d status %0d",
					command, status);
				fail_count++;
			end else begin
				e = due_commands.pop_front();
				if (command !== e.cmd) begin
					$error("command: expected %0d actual %0d", e.cmd, command);
					fail_count++;
				end
				if (mem_address !== e.addr) begin
					$error("mem_address: expected %h actual %h", e.addr, mem_address);
					fail_count++;
				end
				if (write_data !== e.wdata) begin
					$error("write_data: expected %h actual %h", e.wdata, write_data);
					fail_count++;
				end
				if (status !== e.st) begin
					$error("status: expected %0d actual %0d", e.st, status);
					fail_count++;
				end
				if (finished !== e.fin) begin
					$error("finished: expected %0d actual %0d", e.fin, finished);
					fail_count++;
				end
			end
		end
	end

	task automatic add_word(logic act, logic corrupt, logic drain);
		bist_word_t w;
		w.act = act;
		w.corrupt = corrupt;
		w.drain = drain;
		w.noise = $urandom;
		if (corrupt && w.noise == '0)
			w.noise = 32'h1;
		queued_words.push_back(w);
		words_made++;
	endtask

	// every word sent has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (words_taken != words_made || due_commands.size() != 0);
	endtask

	// apb write followed by a read-back of the same register
	task automatic reg_write(logic idx, logic [31:0] val);
		logic [31:0] kept;
		kept = (idx == REG_COUNT) ? (val & 32'h0001_FFFF) : val;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== kept) begin
			$error("register %0d read-back: expected %h actual %h", idx, kept, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_BASE)
			cfg_base_q = val;
		else
			cfg_count_q = val[16:0];
	endtask

	task automatic set_config(logic [31:0] base, logic [31:0] count);
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		reg_write(REG_BASE, base);
		reg_write(REG_COUNT, count);
	endtask

	// a start and then steps: usually the whole march and a spare step or two,
	// sometimes cut short by the next start
	task automatic queue_test(int unsigned n_words, bit brief);
		int unsigned steps;
		add_word(ACT_START, 1'b0, $urandom_range(0, 4) == 0);
		if (brief)
			steps = $urandom_range(1, 6);
		else if ($urandom_range(0, 7) == 0)
			steps = $urandom_range(1, 10 * n_words);
		else
			steps = 10 * n_words + 1 + $urandom_range(0, 2);
		repeat (steps)
			add_word(ACT_STEP, $urandom_range(0, 119) == 0, 1'b0);
	endtask

	// random starts and steps with random data
	task automatic queue_noise();
		repeat ($urandom_range(4, 12))
			add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
	endtask

	initial begin
		int random_goal;
		int unsigned sel;
		logic [31:0] base;
		logic [31:0] count;
		bit brief;

		paddr = '0;
		@(posedge arst_n);

		// after reset: idle step, start on the zero set-up, idle step shows invalid
		add_word(ACT_STEP, 1'b0, 1'b0);
		add_word(ACT_START, 1'b0, 1'b0);
		add_word(ACT_STEP, 1'b0, 1'b0);

		// top of the address space, addresses wrap; junk above the count field
		set_config(32'hFFFF_FFFC, 32'hFFFE_0002);
		add_word(ACT_START, 1'b0, 1'b0);
		for (int i = 0; i < 22; i++)
			add_word(ACT_STEP, 1'b0, i == 10);

		// misaligned base, single word, bad data on the first read
		set_config(32'h0000_1001, 32'd1);
		add_word(ACT_START, 1'b0, 1'b0);
		add_word(ACT_STEP, 1'b0, 1'b0);
		add_word(ACT_STEP, 1'b0, 1'b0);
		add_word(ACT_STEP, 1'b1, 1'b0);
		add_word(ACT_STEP, 1'b0, 1'b0);

		random_goal = words_made + RANDOM_WORDS;
		while (words_made < random_goal) begin
			sel = $urandom_range(0, 19);
			base = $urandom & 32'hFFFF_FFFC;
			if (base == '0)
				base = 32'h4;
			count = $urandom_range(1, 6);
			case (sel)
				0: begin
					// zero base
					base = '0;
					count = $urandom_range(1, 8);
				end
				1: count = '0;
				// above the largest word count
				2: count = $urandom_range(MAX_WORDS + 1, 131071);
				3: begin
					base = 32'hFFFF_FFFC;
					count = $urandom_range(1, 8);
				end
				4: begin
					base = $urandom | 32'h1;
					count = $urandom_range(1, 8);
				end
				// full size, only the start of the march is run
				5: count = MAX_WORDS;
				default: ;
			endcase
			brief = (base == '0 || count == '0 || count > 8);
			set_config(base, count);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 7) == 0)
					queue_noise();
				else
					queue_test(count, brief);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_commands.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
